[src/rltt_pkg.sv]
package rltt_pkg;

  localparam int LOG_SLOTS  = 16;
  localparam int COUNT_W    = $clog2(LOG_SLOTS + 1);
  localparam int IDX_W      = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam int OPS_W      = 5;
  localparam int PC_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 11;

  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_START = 2'd0,
    CFG_REGION    = 2'd1,
    CFG_RESERVE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_WAIT     = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_OUTSIDE  = 3'd3,
    STAT_NO_BEGIN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_COPY   = 2'd1,
    CMD_ENTRY  = 2'd2,
    CMD_HEADER = 2'd3
  } command_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_no;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  command;
    logic [31:0] src_block;
    logic [31:0] dst_block;
    logic [3:0]  entry_index;
    logic [31:0] entry_value;
    logic [4:0]  entry_count;
    logic        last;
  } result_t;

  // Microcode fields.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_SINGLE,
    EM_COPY_OUT,
    EM_ENTRY,
    EM_HDR_CNT,
    EM_COPY_IN,
    EM_HDR_ZERO
  } emit_t;

  typedef enum logic [1:0] {
    CTR_HOLD,
    CTR_CLR,
    CTR_INC
  } ctr_op_t;

  typedef enum logic [2:0] {
    SO_HOLD,
    SO_INC_OPS,
    SO_DEC_OPS,
    SO_APPEND,
    SO_CLR_COUNT
  } st_op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_START,
    C_BEGIN,
    C_END,
    C_UNKNOWN,
    C_TOO_BIG,
    C_NO_OPS,
    C_ADMIT_FAIL,
    C_I_EQ_N,
    C_NO_MATCH,
    C_NO_COMMIT
  } cond_t;

  typedef struct packed {
    logic start;
    logic func_begin;
    logic func_end;
    logic func_unknown;
    logic too_big;
    logic no_ops;
    logic admit_fail;
    logic i_eq_n;
    logic no_match;
    logic no_commit;
  } flags_t;

  typedef struct packed {
    emit_t             emit;
    status_t           status;
    ctr_op_t           ctr;
    st_op_t            st;
    logic              rd;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  // Program labels.
  localparam logic [PC_W-1:0] A_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] A_LOG_WRITE = 5'd4;
  localparam logic [PC_W-1:0] A_SCAN      = 5'd6;
  localparam logic [PC_W-1:0] A_OK        = 5'd8;
  localparam logic [PC_W-1:0] A_APPEND    = 5'd9;
  localparam logic [PC_W-1:0] A_BEGIN     = 5'd10;
  localparam logic [PC_W-1:0] A_END       = 5'd12;
  localparam logic [PC_W-1:0] A_OUT_LOOP  = 5'd14;
  localparam logic [PC_W-1:0] A_HDR_SETUP = 5'd16;
  localparam logic [PC_W-1:0] A_ENT_LOOP  = 5'd17;
  localparam logic [PC_W-1:0] A_HDR_WRITE = 5'd19;
  localparam logic [PC_W-1:0] A_IN_LOOP   = 5'd20;
  localparam logic [PC_W-1:0] A_HDR_CLEAR = 5'd22;
  localparam logic [PC_W-1:0] A_WAIT      = 5'd23;
  localparam logic [PC_W-1:0] A_TOO_BIG   = 5'd24;
  localparam logic [PC_W-1:0] A_OUTSIDE   = 5'd25;
  localparam logic [PC_W-1:0] A_NO_BEGIN  = 5'd26;

  function automatic ctrl_t cw(input emit_t em, input status_t stat, input ctr_op_t ctr,
                               input st_op_t st, input logic rd, input cond_t cond,
                               input logic [PC_W-1:0] target);
    ctrl_t w;
    w.emit   = em;
    w.status = stat;
    w.ctr    = ctr;
    w.st     = st;
    w.rd     = rd;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store. A taken condition jumps to target, otherwise the next word follows.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      A_IDLE:      w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_NO_START, A_IDLE);
      5'd1:        w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_BEGIN, A_BEGIN);
      5'd2:        w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_END, A_END);
      5'd3:        w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_UNKNOWN, A_OK);
      A_LOG_WRITE: w = cw(EM_NONE, STAT_OK, CTR_CLR, SO_HOLD, 1'b0, C_TOO_BIG, A_TOO_BIG);
      5'd5:        w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_NO_OPS, A_OUTSIDE);
      A_SCAN:      w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b1, C_I_EQ_N, A_APPEND);
      5'd7:        w = cw(EM_NONE, STAT_OK, CTR_INC, SO_HOLD, 1'b0, C_NO_MATCH, A_SCAN);
      A_OK:        w = cw(EM_SINGLE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
      A_APPEND:    w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_APPEND, 1'b0, C_ALWAYS, A_OK);
      A_BEGIN:     w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_ADMIT_FAIL, A_WAIT);
      5'd11:       w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_INC_OPS, 1'b0, C_ALWAYS, A_OK);
      A_END:       w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_NO_OPS, A_NO_BEGIN);
      5'd13:       w = cw(EM_NONE, STAT_OK, CTR_CLR, SO_DEC_OPS, 1'b0, C_NO_COMMIT, A_OK);
      A_OUT_LOOP:  w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b1, C_I_EQ_N, A_HDR_SETUP);
      5'd15:       w = cw(EM_COPY_OUT, STAT_OK, CTR_INC, SO_HOLD, 1'b0, C_ALWAYS, A_OUT_LOOP);
      A_HDR_SETUP: w = cw(EM_NONE, STAT_OK, CTR_CLR, SO_HOLD, 1'b0, C_NEVER, A_IDLE);
      A_ENT_LOOP:  w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b1, C_I_EQ_N, A_HDR_WRITE);
      5'd18:       w = cw(EM_ENTRY, STAT_OK, CTR_INC, SO_HOLD, 1'b0, C_ALWAYS, A_ENT_LOOP);
      A_HDR_WRITE: w = cw(EM_HDR_CNT, STAT_OK, CTR_CLR, SO_HOLD, 1'b0, C_NEVER, A_IDLE);
      A_IN_LOOP:   w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b1, C_I_EQ_N, A_HDR_CLEAR);
      5'd21:       w = cw(EM_COPY_IN, STAT_OK, CTR_INC, SO_HOLD, 1'b0, C_ALWAYS, A_IN_LOOP);
      A_HDR_CLEAR: w = cw(EM_HDR_ZERO, STAT_OK, CTR_HOLD, SO_CLR_COUNT, 1'b0, C_ALWAYS, A_IDLE);
      A_WAIT:      w = cw(EM_SINGLE, STAT_WAIT, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
      A_TOO_BIG:   w = cw(EM_SINGLE, STAT_TOO_BIG, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
      A_OUTSIDE:   w = cw(EM_SINGLE, STAT_OUTSIDE, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
      A_NO_BEGIN:  w = cw(EM_SINGLE, STAT_NO_BEGIN, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
      default:     w = cw(EM_NONE, STAT_OK, CTR_HOLD, SO_HOLD, 1'b0, C_ALWAYS, A_IDLE);
    endcase
    return w;
  endfunction

endpackage

[src/redo_log_transaction_tracker_unit.sv]
// Group-commit redo log tracker.
// A request (begin op, end op, or log a block write) is taken on a clock edge
// where start is high and busy is low; busy then stays high until the request's
// last result has been issued. Every result appears on result for exactly one
// cycle with strobe high, and result.last marks the final one of a request.
// The receiver has no way to stall, so results come out at the sequencer's pace.
// Begin, end without commit, unknown and refused requests give a single result.
// A log write scans the stored slots in turn through the slot memory's
// registered read port; it stops at a matching slot, and only a block that is
// not found is appended. A commit issues 3 * logged_count + 2 results, one per
// slot copy or header entry. A new request can be taken in the cycle that the
// previous request's last result is shown.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; an unknown
// index is ignored. The user must make them only while idle, which is not enforced.
// Reset returns the sequencer to idle, empties the log, clears the open
// operation count and reloads the register defaults. The slot memory is not
// cleared; only slots below the logged count are ever used.
module redo_log_transaction_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  rltt_pkg::request_t                   request,
  output logic                                 busy,
  output logic                                 strobe,
  output rltt_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [rltt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rltt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [31:0] log_start;
  logic [15:0] region;
  logic [4:0]  reserve;

  // Tracker state and request latch.
  logic [1:0]                   func_r;
  logic [31:0]                  blk_r;
  logic [rltt_pkg::COUNT_W-1:0] logged_count;
  logic [rltt_pkg::OPS_W-1:0]   open_ops;
  logic [rltt_pkg::COUNT_W-1:0] i;

  rltt_pkg::flags_t  flags;
  rltt_pkg::ctrl_t   ctrl;
  rltt_pkg::result_t result_next;

  logic [31:0]                  rdata;
  logic [rltt_pkg::OPS_W:0]     ops_inc;
  logic [rltt_pkg::PROD_W-1:0]  need;
  logic [31:0]                  slot_block;

  rltt_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  rltt_ram #(
    .WIDTH (32),
    .DEPTH (rltt_pkg::LOG_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ctrl.st == rltt_pkg::SO_APPEND),
    .waddr (logged_count[rltt_pkg::IDX_W-1:0]),
    .wdata (blk_r),
    .re    (ctrl.rd),
    .raddr (i[rltt_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  // Admission: blocks already logged plus a reserve for every op including the new one.
  assign ops_inc    = {1'b0, open_ops} + (rltt_pkg::OPS_W + 1)'(1);
  assign need       = rltt_pkg::PROD_W'(logged_count)
                    + rltt_pkg::PROD_W'(ops_inc) * rltt_pkg::PROD_W'(reserve);
  assign slot_block = log_start + 32'd1 + 32'(i);

  always_comb begin
    flags.start        = start;
    flags.func_begin   = (func_r == rltt_pkg::FUNC_BEGIN);
    flags.func_end     = (func_r == rltt_pkg::FUNC_END);
    flags.func_unknown = (func_r == rltt_pkg::FUNC_NONE);
    flags.too_big      = (logged_count >= rltt_pkg::COUNT_W'(rltt_pkg::LOG_SLOTS))
                      || (16'(logged_count) + 16'd1 >= region);
    flags.no_ops       = (open_ops == '0);
    flags.admit_fail   = (open_ops == '1)
                      || (need > rltt_pkg::PROD_W'(rltt_pkg::LOG_SLOTS));
    flags.i_eq_n       = (i == logged_count);
    flags.no_match     = (rdata != blk_r);
    // The end being decoded closes the last op; commit only with blocks logged.
    flags.no_commit    = (open_ops != rltt_pkg::OPS_W'(1)) || (logged_count == '0);
  end

  always_comb begin
    result_next = '0;
    case (ctrl.emit)
      rltt_pkg::EM_SINGLE: begin
        result_next.status = ctrl.status;
        result_next.last   = 1'b1;
      end
      rltt_pkg::EM_COPY_OUT: begin
        result_next.command     = rltt_pkg::CMD_COPY;
        result_next.src_block   = rdata;
        result_next.dst_block   = slot_block;
        result_next.entry_index = 4'(i);
      end
      rltt_pkg::EM_ENTRY: begin
        result_next.command     = rltt_pkg::CMD_ENTRY;
        result_next.dst_block   = log_start;
        result_next.entry_index = 4'(i);
        result_next.entry_value = rdata;
      end
      rltt_pkg::EM_HDR_CNT: begin
        result_next.command     = rltt_pkg::CMD_HEADER;
        result_next.dst_block   = log_start;
        result_next.entry_count = 5'(logged_count);
      end
      rltt_pkg::EM_COPY_IN: begin
        result_next.command     = rltt_pkg::CMD_COPY;
        result_next.src_block   = slot_block;
        result_next.dst_block   = rdata;
        result_next.entry_index = 4'(i);
      end
      rltt_pkg::EM_HDR_ZERO: begin
        result_next.command   = rltt_pkg::CMD_HEADER;
        result_next.dst_block = log_start;
        result_next.last      = 1'b1;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      log_start <= 32'd2;
      region    <= 16'd17;
      reserve   <= 5'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        rltt_pkg::CFG_LOG_START: log_start <= cfg_data;
        rltt_pkg::CFG_REGION:    region    <= cfg_data[15:0];
        rltt_pkg::CFG_RESERVE:   reserve   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= request.func;
      blk_r  <= request.block_no;
    end
    case (ctrl.ctr)
      rltt_pkg::CTR_CLR: i <= '0;
      rltt_pkg::CTR_INC: i <= i + rltt_pkg::COUNT_W'(1);
      default: begin
      end
    endcase
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logged_count <= '0;
      open_ops     <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= (ctrl.emit != rltt_pkg::EM_NONE);
      case (ctrl.st)
        rltt_pkg::SO_INC_OPS:   open_ops     <= open_ops + rltt_pkg::OPS_W'(1);
        rltt_pkg::SO_DEC_OPS:   open_ops     <= open_ops - rltt_pkg::OPS_W'(1);
        rltt_pkg::SO_APPEND:    logged_count <= logged_count + rltt_pkg::COUNT_W'(1);
        rltt_pkg::SO_CLR_COUNT: logged_count <= '0;
        default: begin
        end
      endcase
    end
  end

  // A result that is not the last of its request is only issued mid-request.
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("non-final result beat while idle");

  // The closing header write of a commit leaves the log empty.
  a_commit_empties: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last && (result.command == rltt_pkg::CMD_HEADER)
    |-> (logged_count == '0))
    else $error("log not empty after commit");

  // The sequencer only leaves idle on an accepted request.
  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");

endmodule

[src/rltt_ram.sv]
module rltt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rltt_seq.sv]
module rltt_seq (
  input  logic            clk,
  input  logic            rst,
  input  rltt_pkg::flags_t flags,
  output rltt_pkg::ctrl_t  ctrl,
  output logic            busy
);

  logic [rltt_pkg::PC_W-1:0] pc;
  logic [rltt_pkg::PC_W-1:0] pc_next;
  logic                      taken;

  assign ctrl = rltt_pkg::ucode(pc);
  assign busy = (pc != rltt_pkg::A_IDLE);

  always_comb begin
    case (ctrl.cond)
      rltt_pkg::C_ALWAYS:     taken = 1'b1;
      rltt_pkg::C_NEVER:      taken = 1'b0;
      rltt_pkg::C_NO_START:   taken = !flags.start;
      rltt_pkg::C_BEGIN:      taken = flags.func_begin;
      rltt_pkg::C_END:        taken = flags.func_end;
      rltt_pkg::C_UNKNOWN:    taken = flags.func_unknown;
      rltt_pkg::C_TOO_BIG:    taken = flags.too_big;
      rltt_pkg::C_NO_OPS:     taken = flags.no_ops;
      rltt_pkg::C_ADMIT_FAIL: taken = flags.admit_fail;
      rltt_pkg::C_I_EQ_N:     taken = flags.i_eq_n;
      rltt_pkg::C_NO_MATCH:   taken = flags.no_match;
      rltt_pkg::C_NO_COMMIT:  taken = flags.no_commit;
      default:                taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + rltt_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rltt_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[test/commit_log_checker.sv]
module commit_log_checker
  import rltt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  request_t              request,
  input  logic                  busy,
  input  logic                  strobe,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] log_start_q;
  logic [15:0] region_q;
  logic [4:0]  reserve_q;
  logic [31:0] home_blocks [LOG_SLOTS];
  int unsigned n_logged;
  int unsigned n_open;
  result_t     pending_commands [$];

  function automatic result_t make_result(input status_t st, input command_t cmd,
                                          input logic [31:0] src, input logic [31:0] dst,
                                          input logic [3:0] idx, input logic [31:0] val,
                                          input logic [4:0] cnt, input logic fin);
    result_t r;
    r.status      = st;
    r.command     = cmd;
    r.src_block   = src;
    r.dst_block   = dst;
    r.entry_index = idx;
    r.entry_value = val;
    r.entry_count = cnt;
    r.last        = fin;
    return r;
  endfunction

  function automatic result_t single_answer(input status_t st);
    return make_result(st, CMD_NONE, '0, '0, '0, '0, '0, 1'b1);
  endfunction

  // Works out every command that one request causes and queues them in order.
  task automatic model_request(input request_t rq);
    int unsigned i;
    case (func_t'(rq.func))
      FUNC_BEGIN: begin
        if (n_open >= 31 || n_logged + (n_open + 1) * reserve_q > LOG_SLOTS) begin
          pending_commands.push_back(single_answer(STAT_WAIT));
        end else begin
          n_open++;
          pending_commands.push_back(single_answer(STAT_OK));
        end
      end
      FUNC_WRITE: begin
        if (n_logged >= LOG_SLOTS || n_logged + 1 >= region_q) begin
          pending_commands.push_back(single_answer(STAT_TOO_BIG));
        end else if (n_open == 0) begin
          pending_commands.push_back(single_answer(STAT_OUTSIDE));
        end else begin
          // A block already in the log is absorbed and takes no new slot.
          for (i = 0; i < n_logged; i++) begin
            if (home_blocks[i] == rq.block_no) break;
          end
          if (i == n_logged) begin
            home_blocks[i] = rq.block_no;
            n_logged++;
          end
          pending_commands.push_back(single_answer(STAT_OK));
        end
      end
      FUNC_END: begin
        if (n_open == 0) begin
          pending_commands.push_back(single_answer(STAT_NO_BEGIN));
        end else begin
          n_open--;
          if (n_open != 0 || n_logged == 0) begin
            pending_commands.push_back(single_answer(STAT_OK));
          end else begin
            for (i = 0; i < n_logged; i++)
              pending_commands.push_back(make_result(STAT_OK, CMD_COPY, home_blocks[i],
                log_start_q + 32'd1 + i, i[3:0], '0, '0, 1'b0));
            for (i = 0; i < n_logged; i++)
              pending_commands.push_back(make_result(STAT_OK, CMD_ENTRY, '0, log_start_q,
                i[3:0], home_blocks[i], '0, 1'b0));
            pending_commands.push_back(make_result(STAT_OK, CMD_HEADER, '0, log_start_q,
              '0, '0, n_logged[4:0], 1'b0));
            for (i = 0; i < n_logged; i++)
              pending_commands.push_back(make_result(STAT_OK, CMD_COPY,
                log_start_q + 32'd1 + i, home_blocks[i], i[3:0], '0, '0, 1'b0));
            pending_commands.push_back(make_result(STAT_OK, CMD_HEADER, '0, log_start_q,
              '0, '0, '0, 1'b1));
            n_logged = 0;
          end
        end
      end
      default: pending_commands.push_back(single_answer(STAT_OK));
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    bit      bad;
    if (rst) begin
      log_start_q = 32'd2;
      region_q    = 16'd17;
      reserve_q   = 5'd5;
      n_logged    = 0;
      n_open      = 0;
      errors      = 0;
      pending_commands.delete();
    end else begin
      if (strobe) begin
        if (pending_commands.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d command %0d",
                   $time, result.status, result.command);
          errors++;
        end else begin
          want = pending_commands.pop_front();
          bad  = 1'b0;
          compare_field("status", 32'(want.status), 32'(result.status), bad);
          compare_field("command", 32'(want.command), 32'(result.command), bad);
          compare_field("src_block", want.src_block, result.src_block, bad);
          compare_field("dst_block", want.dst_block, result.dst_block, bad);
          compare_field("entry_index", 32'(want.entry_index), 32'(result.entry_index), bad);
          compare_field("entry_value", want.entry_value, result.entry_value, bad);
          compare_field("entry_count", 32'(want.entry_count), 32'(result.entry_count), bad);
          compare_field("last", 32'(want.last), 32'(result.last), bad);
          if (bad) errors++;
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_LOG_START: log_start_q = cfg_data;
          CFG_REGION:    region_q    = cfg_data[15:0];
          CFG_RESERVE:   reserve_q   = cfg_data[4:0];
          default: ;
        endcase
      end
      if (start && !busy) model_request(request);
    end
    outstanding = pending_commands.size();
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rltt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  request_t              request;
  logic                  busy;
  logic                  strobe;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  int          items_sent;
  int          idle_pct;
  logic [31:0] block_pool [8];

  always #5 clk = ~clk;

  redo_log_transaction_tracker_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  commit_log_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .strobe      (strobe),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  function automatic logic [31:0] pick_block(input bit fresh);
    if (fresh) return $urandom;
    case ($urandom_range(0, 3))
      0, 1: return block_pool[$urandom_range(0, 7)];
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0: return 32'h0;
          1: return 32'hFFFF_FFFF;
          default: return 32'h1 << $urandom_range(0, 31);
        endcase
      end
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge after the beat is taken.
  // Start stays high so back-to-back requests need no gap, unless an idle gap is drawn.
  task automatic issue(input func_t f, input logic [31:0] blk);
    start   <= 1'b1;
    request <= {f, blk};
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (f != FUNC_NONE) items_sent++;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // Holds off the next request until every queued command has come out.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] ls, input logic [15:0] blocks,
                              input logic [4:0] rsv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOG_START;
    cfg_data  <= ls;
    @(negedge clk);
    cfg_index <= CFG_REGION;
    cfg_data  <= {16'h0, blocks};
    @(negedge clk);
    cfg_index <= CFG_RESERVE;
    cfg_data  <= {27'h0, rsv};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One well-formed group of operations: begins, block writes, then the matching ends.
  task automatic log_transaction();
    int ops;
    int writes;
    bit bulk;
    ops    = $urandom_range(1, 3);
    bulk   = ($urandom_range(0, 3) == 0);
    writes = bulk ? $urandom_range(12, 20) : $urandom_range(0, 6);
    repeat (ops) issue(FUNC_BEGIN, pick_block(1'b1));
    repeat (writes) issue(FUNC_WRITE, pick_block(bulk && $urandom_range(0, 3) != 0));
    for (int k = 0; k < ops; k++) begin
      issue(FUNC_END, pick_block(1'b1));
      if (k + 1 < ops && $urandom_range(0, 2) == 0) issue(FUNC_WRITE, pick_block(1'b0));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LOG_START;
    cfg_data   = '0;
    items_sent = 0;
    idle_pct   = 0;
    for (int i = 0; i < 8; i++) block_pool[i] = (i < 4) ? i : $urandom;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Register defaults after reset: header at block 2, 17-block region, reserve 5.
    issue(FUNC_END, 32'h0);
    issue(FUNC_WRITE, 32'h0);
    issue(FUNC_NONE, 32'hFFFF_FFFF);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_WRITE, 32'h0);
    issue(FUNC_WRITE, 32'hFFFF_FFFF);
    issue(FUNC_WRITE, 32'h0);
    issue(FUNC_WRITE, 32'h5555_AAAA);
    issue(FUNC_END, 32'h0);
    issue(FUNC_WRITE, 32'hAAAA_5555);
    issue(FUNC_END, 32'h0);
    issue(FUNC_END, 32'h0);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_END, 32'h0);
    settle();

    // Header at the top of the block space, so slot addresses wrap to zero.
    program_regs(32'hFFFF_FFFF, 16'd2, 5'd16);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_BEGIN, 32'h0);
    issue(FUNC_WRITE, 32'h1234_5678);
    issue(FUNC_WRITE, 32'h0000_0009);
    issue(FUNC_END, 32'h0);
    issue(FUNC_WRITE, 32'h0000_0001);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: program_regs(32'd2, 16'd17, 5'd5);
        1: program_regs(32'hFFFF_FFF0, 16'hFFFF, 5'd1);
        2: program_regs($urandom, 16'd2, 5'd16);
        3: program_regs(32'd0, 16'd9, 5'd3);
        4: program_regs($urandom, 16'($urandom_range(2, 20)), 5'($urandom_range(1, 16)));
        default: program_regs($urandom, 16'($urandom_range(2, 65535)),
                              5'($urandom_range(1, 16)));
      endcase
      case (p)
        0: idle_pct = 20;
        2: idle_pct = 30;
        3: idle_pct = 15;
        4: idle_pct = 25;
        default: idle_pct = 0;
      endcase
      while (items_sent < 23 + 67 * (p + 1)) begin
        if ($urandom_range(0, 6) == 0)
          issue(func_t'($urandom_range(0, 3)), pick_block(1'($urandom_range(0, 1))));
        else
          log_transaction();
        if ($urandom_range(0, 14) == 0) settle();
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
src/rltt_pkg.sv
src/rltt_ram.sv
src/rltt_seq.sv
src/redo_log_transaction_tracker_unit.sv
test/commit_log_checker.sv
test/tb.sv
